FILE: rtl/fwt_pkg.sv
package fwt_pkg;

    localparam int CMD_W   = 4;
    localparam int IDX_W   = 11;
    localparam int VAL_W   = 32;
    localparam int FOUND_W = 12;
    localparam int CFG_IW  = 1;
    localparam int CFG_DW  = 11;

    localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [CFG_IW-1:0] CFG_SIZE_IN_USE   = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_REVERSED_MODE = 1'd1;

    localparam logic [CMD_W-1:0] CMD_ADD         = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SET         = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PREFIX      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RANGE       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_POINT       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_LOWER       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_UPPER       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_LOWER_BEGIN = 4'd7;
    localparam logic [CMD_W-1:0] CMD_UPPER_BEGIN = 4'd8;
    localparam logic [CMD_W-1:0] CMD_TOTAL       = 4'd9;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]   sum_value;
        logic signed [FOUND_W-1:0] found_index;
        logic                      status;
    } t_out_item;

endpackage

FILE: rtl/fwt_ram.sv
module fwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fenwick_tree_engine.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_data  (cmd, index_a, index_b, value)
// out       output     o_out_valid / i_out_stall o_out_data (sum_value, found_index, status)
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One transaction at a time; the single read port of the node RAM sets the pace.
// Prefix walks read one node per cycle; range and point run two prefix walks, set two
// prefix walks and an add walk, searches a read and a compare per tree level. After
// reset the node RAM is zeroed, one entry per cycle, with o_in_stall high. A stalled
// result sits in the output register while the next transaction is taken; the
// engine waits only when a second result is ready.
module fenwick_tree_engine #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fwt_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output fwt_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [fwt_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic [fwt_pkg::CFG_DW-1:0]     i_cfg_data
);

    import fwt_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int XW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = (XW > IDX_W) ? XW : IDX_W;
    localparam int SW = NW + 2;

    localparam logic signed [SW-1:0] ONE   = SW'(1);
    localparam logic [NW-1:0]        W_ONE = NW'(1);
    localparam logic [NW-1:0]        N_MAX = NW'(MAX_ENTRIES);
    localparam logic [AW-1:0]        A_END = AW'(MAX_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_PFX, ST_ADD, ST_DREQ, ST_DCMP, ST_FIN
    } t_state;

    typedef enum logic [1:0] {NX_FIN, NX_ADD, NX_DESC} t_next;

    function automatic logic [NW-1:0] top_pow(input logic [NW-1:0] v);
        logic [NW-1:0] r;
        r = '0;
        for (int k = 0; k < NW; k++) begin
            if (v[k]) r = W_ONE << k;
        end
        return r;
    endfunction

    // configuration
    logic [IDX_W-1:0] r_size;
    logic             r_rev;

    // sequencer
    t_state                  r_state;
    t_next                   r_next;
    logic [CMD_W-1:0]        r_cmd;
    logic                    r_err;
    logic                    r_two;
    logic                    r_second;
    logic signed [SW-1:0]    r_idx;
    logic signed [SW-1:0]    r_m2;
    logic signed [SW-1:0]    r_k;
    logic signed [SW-1:0]    r_a;
    logic signed [SW-1:0]    r_i;
    logic signed [SW-1:0]    r_j;
    logic [NW-1:0]           r_w;
    logic [VAL_W-1:0]        r_acc;
    logic [VAL_W-1:0]        r_x;
    logic [VAL_W-1:0]        r_delta;
    logic                    r_rpend;
    logic                    r_neg;
    logic                    r_wpend;
    logic [AW-1:0]           r_waddr;
    logic [AW-1:0]           r_clr;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [NW-1:0]           size_nw;
    logic [NW-1:0]           act_nu;
    logic signed [SW-1:0]    act_n;
    logic [NW-1:0]           pw;
    logic signed [SW-1:0]    a_s;
    logic signed [SW-1:0]    b_s;
    logic signed [SW-1:0]    a_mir;
    logic signed [SW-1:0]    j_s;
    logic signed [SW-1:0]    f_s;
    logic signed [SW-1:0]    f_out;
    logic                    strict;
    logic                    go;
    logic                    out_free;
    t_out_item               fin_item;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    always_comb begin
        size_nw = NW'(r_size);
        if (size_nw == '0) begin
            act_nu = W_ONE;
        end else if (size_nw > N_MAX) begin
            act_nu = N_MAX;
        end else begin
            act_nu = size_nw;
        end
    end

    assign act_n = signed'({2'b00, act_nu});
    assign pw    = top_pow(act_nu);
    assign a_s   = signed'(SW'(i_in_data.index_a));
    assign b_s   = signed'(SW'(i_in_data.index_b));
    assign a_mir = act_n - ONE - a_s;
    assign j_s   = r_i + signed'(SW'(r_w));

    assign strict = (r_cmd == CMD_UPPER) || (r_cmd == CMD_UPPER_BEGIN);
    assign go     = strict ? !($signed(r_x) < $signed(ram_rdata))
                           : ($signed(ram_rdata) < $signed(r_x));

    // result assembly
    always_comb begin
        f_s   = r_i + ONE;
        f_out = '0;
        if ((r_cmd == CMD_LOWER) || (r_cmd == CMD_UPPER)) begin
            f_out = r_rev ? (act_n - ONE - f_s) : f_s;
        end else if ((r_cmd == CMD_LOWER_BEGIN) || (r_cmd == CMD_UPPER_BEGIN)) begin
            f_out = (f_s < r_a) ? r_a : f_s;
        end
        fin_item.status      = r_err;
        fin_item.found_index = r_err ? '0 : f_out[FOUND_W-1:0];
        if (!r_err && ((r_cmd == CMD_PREFIX) || (r_cmd == CMD_RANGE) ||
                       (r_cmd == CMD_POINT) || (r_cmd == CMD_TOTAL))) begin
            fin_item.sum_value = signed'(r_acc);
        end else begin
            fin_item.sum_value = '0;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // RAM ports: the write port clears, then serves add walks in the cycle after each read
    assign ram_we    = (r_state == ST_CLEAR) || r_wpend;
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr : r_waddr;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : (ram_rdata + r_delta);
    assign ram_raddr = (r_state == ST_DREQ) ? j_s[AW-1:0] : r_idx[AW-1:0];

    fwt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_rev  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_IN_USE:   r_size <= i_cfg_data;
                CFG_REVERSED_MODE: r_rev  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_rpend     <= 1'b0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_rpend) begin
                r_acc <= r_neg ? (r_acc - ram_rdata) : (r_acc + ram_rdata);
            end

            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= fin_item;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == A_END) r_state <= ST_IDLE;
                end

                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd    <= i_in_data.cmd;
                        r_a      <= a_s;
                        r_x      <= i_in_data.value;
                        r_err    <= 1'b0;
                        r_two    <= 1'b0;
                        r_second <= 1'b0;
                        r_acc    <= '0;
                        r_i      <= '1;
                        r_w      <= pw;
                        r_next   <= NX_FIN;
                        case (i_in_data.cmd)
                            CMD_ADD: begin
                                if (a_s >= act_n) begin
                                    r_err   <= 1'b1;
                                    r_state <= ST_FIN;
                                end else begin
                                    r_idx   <= r_rev ? a_mir : a_s;
                                    r_delta <= i_in_data.value;
                                    r_state <= ST_ADD;
                                end
                            end
                            CMD_SET: begin
                                if (a_s >= act_n) begin
                                    r_err   <= 1'b1;
                                    r_state <= ST_FIN;
                                end else begin
                                    r_idx   <= a_s;
                                    r_m2    <= a_s - ONE;
                                    r_two   <= 1'b1;
                                    r_k     <= a_s;
                                    r_next  <= NX_ADD;
                                    r_state <= ST_PFX;
                                end
                            end
                            CMD_PREFIX: begin
                                if (a_s > act_n) begin
                                    r_err   <= 1'b1;
                                    r_state <= ST_FIN;
                                end else begin
                                    // mirrored end N-1-a gives the suffix sum
                                    r_idx   <= (r_rev ? a_mir : a_s) - ONE;
                                    r_state <= ST_PFX;
                                end
                            end
                            CMD_RANGE: begin
                                if ((a_s > b_s) || (b_s > act_n)) begin
                                    r_err   <= 1'b1;
                                    r_state <= ST_FIN;
                                end else begin
                                    r_idx   <= b_s - ONE;
                                    r_m2    <= a_s - ONE;
                                    r_two   <= 1'b1;
                                    r_state <= ST_PFX;
                                end
                            end
                            CMD_POINT: begin
                                if (a_s >= act_n) begin
                                    r_err   <= 1'b1;
                                    r_state <= ST_FIN;
                                end else begin
                                    r_idx   <= a_s;
                                    r_m2    <= a_s - ONE;
                                    r_two   <= 1'b1;
                                    r_state <= ST_PFX;
                                end
                            end
                            CMD_LOWER, CMD_UPPER: begin
                                r_state <= ST_DREQ;
                            end
                            CMD_LOWER_BEGIN, CMD_UPPER_BEGIN: begin
                                if (a_s > act_n) begin
                                    r_err   <= 1'b1;
                                    r_state <= ST_FIN;
                                end else begin
                                    r_idx   <= a_s - ONE;
                                    r_next  <= NX_DESC;
                                    r_state <= ST_PFX;
                                end
                            end
                            CMD_TOTAL: begin
                                r_idx   <= act_n - ONE;
                                r_state <= ST_PFX;
                            end
                            default: begin
                                r_err   <= 1'b1;
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end

                ST_PFX: begin
                    // read addresses do not depend on data, so one read per cycle
                    if (!r_idx[SW-1]) begin
                        r_rpend <= 1'b1;
                        r_neg   <= r_second;
                        r_idx   <= (r_idx & (r_idx + ONE)) - ONE;
                    end else begin
                        r_rpend <= 1'b0;
                        if (!r_rpend) begin
                            if (r_two && !r_second) begin
                                r_second <= 1'b1;
                                r_idx    <= r_m2;
                            end else begin
                                case (r_next)
                                    NX_ADD: begin
                                        r_delta <= r_x - r_acc;
                                        r_idx   <= r_k;
                                        r_state <= ST_ADD;
                                    end
                                    NX_DESC: begin
                                        r_x     <= r_x + r_acc;
                                        r_state <= ST_DREQ;
                                    end
                                    default: r_state <= ST_FIN;
                                endcase
                            end
                        end
                    end
                end

                ST_ADD: begin
                    // write-back follows in the cycle after the read; walk addresses never repeat
                    if (r_idx < act_n) begin
                        r_wpend <= 1'b1;
                        r_waddr <= r_idx[AW-1:0];
                        r_idx   <= r_idx | (r_idx + ONE);
                    end else begin
                        r_wpend <= 1'b0;
                        if (!r_wpend) r_state <= ST_FIN;
                    end
                end

                ST_DREQ: begin
                    if (j_s < act_n) begin
                        r_j     <= j_s;
                        r_state <= ST_DCMP;
                    end else begin
                        r_w <= r_w >> 1;
                        if (r_w == W_ONE) r_state <= ST_FIN;
                    end
                end

                ST_DCMP: begin
                    if (go) begin
                        r_x <= r_x - ram_rdata;
                        r_i <= r_j;
                    end
                    r_w     <= r_w >> 1;
                    r_state <= (r_w == W_ONE) ? ST_FIN : ST_DREQ;
                end

                ST_FIN: begin
                    if (out_free) r_state <= ST_IDLE;
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_wpend_in_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> (r_state == ST_ADD))
        else $error("node write-back pending outside add walk");

    a_rpend_in_pfx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rpend |-> (r_state == ST_PFX))
        else $error("prefix read pending outside prefix walk");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!r_wpend && !r_rpend && o_in_stall))
        else $error("activity during clearing pass");

    a_cmp_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DCMP) |-> ($past(r_state) == ST_DREQ))
        else $error("descent compare without a read");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result raised outside finish state");
`endif

endmodule

FILE: tb/tb_fenwick_tree_engine.sv
module tb_fenwick_tree_engine;
    import fwt_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int LONG_HOLD = 300;
    localparam int N_PHASES  = 12;
    // size 0 and anything above DEPTH are folded back into range by the block
    localparam int PHASE_SIZE  [N_PHASES] = '{16, 16, 1, 0, 2, 3, 7, 1024, 2047, 100, 1500, 33};
    localparam bit PHASE_REV   [N_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 1, 0};
    localparam int PHASE_ITEMS [N_PHASES] = '{80, 80, 40, 30, 40, 40, 60, 60, 40, 80, 30, 100};
    localparam int HOLD_PHASE  = 9;

    // first and last of the unassigned command codes
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd10;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

    class fenwick_scoreboard;
        logic [VAL_W-1:0] nodes [DEPTH];
        int unsigned      size_reg;
        bit               mirrored;
        t_out_item        expected_q [$];
        int               errors;
        int               checked;

        function new();
            foreach (nodes[i]) nodes[i] = '0;
            size_reg = SIZE_RESET;
            mirrored = 1'b0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            if (idx == CFG_SIZE_IN_USE) begin
                size_reg = data;
            end else if (idx == CFG_REVERSED_MODE) begin
                mirrored = data[0];
            end
        endfunction

        function int eff_size();
            int n;
            n = size_reg;
            if (n < 1) n = 1;
            if (n > DEPTH) n = DEPTH;
            return n;
        endfunction

        function void bump(int n, int k, logic [VAL_W-1:0] amount);
            for (int i = k; i >= 0 && i < n; i = i | (i + 1))
                nodes[i] += amount;
        endfunction

        // sum of entries [0, m)
        function logic [VAL_W-1:0] prefix_sum(int n, int m);
            logic [VAL_W-1:0] acc;
            acc = '0;
            if (m > n) m = n;
            for (int i = m - 1; i >= 0; i = (i & (i + 1)) - 1)
                acc += nodes[i];
            return acc;
        endfunction

        // binary descent: smallest i with prefix(i+1) >= thr, or > thr when strictly
        function int descend(int n, logic [VAL_W-1:0] thr, bit strictly);
            int               pw;
            int               pos;
            int               j;
            logic [VAL_W-1:0] node;
            logic [VAL_W-1:0] rem;
            bit               go;
            pw  = 1;
            pos = -1;
            rem = thr;
            while (pw <= n / 2) pw = pw * 2;
            for (int w = pw; w > 0; w = w / 2) begin
                j = pos + w;
                if (j < n) begin
                    node = nodes[j];
                    go = strictly ? !($signed(rem) < $signed(node))
                                  : ($signed(node) < $signed(rem));
                    if (go) begin
                        rem = rem - node;
                        pos = j;
                    end
                end
            end
            return pos + 1;
        endfunction

        function void note_input(t_in_item it);
            int               n;
            int               a;
            int               b;
            int               found;
            logic [VAL_W-1:0] x;
            logic [VAL_W-1:0] sum;
            bit               err;
            t_out_item        e;
            n     = eff_size();
            a     = int'(it.index_a);
            b     = int'(it.index_b);
            x     = it.value;
            sum   = '0;
            found = 0;
            err   = 1'b0;
            case (it.cmd)
                CMD_ADD: begin
                    if (a >= n) err = 1'b1;
                    else bump(n, mirrored ? n - 1 - a : a, x);
                end
                CMD_SET: begin
                    if (a >= n) err = 1'b1;
                    else bump(n, a, x - (prefix_sum(n, a + 1) - prefix_sum(n, a)));
                end
                CMD_PREFIX: begin
                    if (a > n) err = 1'b1;
                    else sum = prefix_sum(n, mirrored ? n - 1 - a : a);
                end
                CMD_RANGE: begin
                    if (a > b || b > n) err = 1'b1;
                    else sum = prefix_sum(n, b) - prefix_sum(n, a);
                end
                CMD_POINT: begin
                    if (a >= n) err = 1'b1;
                    else sum = prefix_sum(n, a + 1) - prefix_sum(n, a);
                end
                CMD_LOWER, CMD_UPPER: begin
                    found = descend(n, x, it.cmd == CMD_UPPER);
                    if (mirrored) found = n - 1 - found;
                end
                CMD_LOWER_BEGIN, CMD_UPPER_BEGIN: begin
                    if (a > n) begin
                        err = 1'b1;
                    end else begin
                        found = descend(n, x + prefix_sum(n, a), it.cmd == CMD_UPPER_BEGIN);
                        if (found < a) found = a;
                    end
                end
                CMD_TOTAL: begin
                    sum = prefix_sum(n, n);
                end
                default: begin
                    err = 1'b1;
                end
            endcase
            if (err) begin
                sum   = '0;
                found = 0;
            end
            e.sum_value   = sum;
            e.found_index = found[FOUND_W-1:0];
            e.status      = err;
            expected_q.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result sum %0d found %0d status %0b",
                         $time, got.sum_value, got.found_index, got.status);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.sum_value !== e.sum_value || got.found_index !== e.found_index ||
                got.status !== e.status) begin
                $display("%0t: expected sum %0d found %0d status %0b, actual sum %0d found %0d status %0b",
                         $time, e.sum_value, e.found_index, e.status,
                         got.sum_value, got.found_index, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IW-1:0]     i_cfg_idx;
    logic [CFG_DW-1:0]     i_cfg_data;

    fenwick_scoreboard sb = new();
    bit                gaps_on = 1'b1;
    bit                long_hold_req = 1'b0;
    int                n_sent = 0;
    int                n_settings = 0;

    fenwick_tree_engine #(.MAX_ENTRIES(DEPTH)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    // receiver side: random stall bursts, plus one long hold-off to back the block up
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
                long_hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("fenwick_tree_engine: mismatch");
        $finish;
    end

    task automatic send_item(t_in_item it);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(it);
        n_sent++;
    endtask

    task automatic send_cmd(logic [CMD_W-1:0] cmd, int a, int b, logic [VAL_W-1:0] v);
        t_in_item it;
        it.cmd     = cmd;
        it.index_a = a[IDX_W-1:0];
        it.index_b = b[IDX_W-1:0];
        it.value   = v;
        send_item(it);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_DW-1:0];
        @(posedge i_clk);
        sb.write_reg(idx, data[CFG_DW-1:0]);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0 && guard < 50_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    // indices lean on the edges of the active range, with some outside it
    function automatic int pick_index(int n);
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return n - 1;
            2:       return n;
            3:       return $urandom_range(0, 2047);
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item         it;
        int               n;
        int               r;
        int               b;
        logic [VAL_W-1:0] tot;
        n   = sb.eff_size();
        tot = sb.prefix_sum(n, n);
        r   = $urandom_range(0, 99);
        it.index_a = IDX_W'(pick_index(n));
        it.index_b = IDX_W'($urandom_range(0, 2047));
        if ($signed(tot) > 0 && $signed(tot) < 1_000_000)
            it.value = $urandom_range(0, tot + 2);
        else
            it.value = $urandom;
        if (r < 30)      it.cmd = CMD_ADD;
        else if (r < 40) it.cmd = CMD_SET;
        else if (r < 50) it.cmd = CMD_PREFIX;
        else if (r < 58) it.cmd = CMD_RANGE;
        else if (r < 66) it.cmd = CMD_POINT;
        else if (r < 74) it.cmd = CMD_LOWER;
        else if (r < 82) it.cmd = CMD_UPPER;
        else if (r < 88) it.cmd = CMD_LOWER_BEGIN;
        else if (r < 94) it.cmd = CMD_UPPER_BEGIN;
        else if (r < 97) it.cmd = CMD_TOTAL;
        else             it.cmd = CMD_W'($urandom_range(0, 15));
        if (it.cmd == CMD_ADD || it.cmd == CMD_SET) begin
            // positive entries keep the bound searches meaningful
            it.value = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 1000);
        end else if (it.cmd == CMD_RANGE) begin
            b = pick_index(n);
            it.index_b = IDX_W'(b);
            it.index_a = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 2047))
                                                     : IDX_W'($urandom_range(0, b));
        end
        return it;
    endfunction

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // node RAM clearing pass
        while (o_in_stall) @(posedge i_clk);

        // directed: reset settings, full size, field extremes and error cases
        send_cmd(CMD_TOTAL, 0, 0, '0);
        send_cmd(CMD_ADD, 0, 2047, 32'd5);
        send_cmd(CMD_ADD, 1023, 0, 32'h7fff_ffff);
        send_cmd(CMD_ADD, 1023, 0, 32'd1);
        send_cmd(CMD_SET, 512, 0, 32'h8000_0000);
        send_cmd(CMD_SET, 512, 0, 32'd7);
        send_cmd(CMD_PREFIX, 1024, 0, '1);
        send_cmd(CMD_PREFIX, 0, 0, '0);
        send_cmd(CMD_PREFIX, 1025, 0, '0);
        send_cmd(CMD_RANGE, 0, 1024, '0);
        send_cmd(CMD_RANGE, 5, 5, '0);
        send_cmd(CMD_RANGE, 10, 3, '0);
        send_cmd(CMD_RANGE, 0, 2047, '0);
        send_cmd(CMD_POINT, 1023, 0, '0);
        send_cmd(CMD_POINT, 1024, 0, '0);
        send_cmd(CMD_ADD, 2047, 0, 32'd1);
        send_cmd(CMD_SET, 1024, 0, 32'd1);
        send_cmd(CMD_LOWER, 0, 0, 32'd5);
        send_cmd(CMD_UPPER, 0, 0, 32'd5);
        send_cmd(CMD_UPPER, 0, 0, 32'hffff_ffff);
        send_cmd(CMD_LOWER_BEGIN, 1, 0, 32'd0);
        send_cmd(CMD_UPPER_BEGIN, 1024, 0, 32'd100);
        send_cmd(CMD_LOWER_BEGIN, 1025, 0, 32'd0);
        send_cmd(CMD_UNUSED_FIRST, 0, 0, '0);
        send_cmd(CMD_UNUSED_LAST, 2047, 2047, '1);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            write_reg(CFG_SIZE_IN_USE, PHASE_SIZE[p]);
            write_reg(CFG_REVERSED_MODE, PHASE_REV[p]);
            n_settings++;
            if (p == HOLD_PHASE) long_hold_req = 1'b1;
            // last setting runs with both sides flat out
            if (p == N_PHASES - 1) gaps_on = 1'b0;
            for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
                send_item(random_item());
            end
        end
        wait_idle();
        repeat (100) @(posedge i_clk);

        $display("%0d commands sent, %0d results checked over %0d size/orientation settings",
                 n_sent, sb.checked, n_settings);
        $display("sizes 0..2047 incl. folded ones, plain and mirrored, bad indices, unknown codes");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("fenwick_tree_engine: match");
        end else begin
            $display("fenwick_tree_engine: mismatch");
        end
        $finish;
    end

endmodule
